// ===== sv/etsg_pkg.sv =====
// Shared types, constants and helpers for the edge triangle set gather block.
// No dependencies; every other file in this folder but etsg_ram imports it.
`default_nettype none
package etsg_pkg;

  // field widths fixed by the item format
  localparam int OP_W      = 2;
  localparam int EDGE_W    = 11;
  localparam int VAL_W     = 11;
  localparam int IDX_W     = 10;
  localparam int REM_W     = 11;

  // bitmap word geometry
  localparam int WORD_W    = 32;
  localparam int BIT_W     = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_NEXT  = 2'd2;

  // stored value that ends an edge's slot list
  localparam logic [VAL_W-1:0] END_MARK = 11'h7FF;

  // controller to datapath commands
  typedef struct packed {
    logic adj_wr;    // write adjacency slot from the input beat
    logic latch;     // capture edge, restart slot count
    logic slot_inc;  // advance to next slot
    logic mark_rd;   // read bitmap word of the slot's triangle
    logic mark_upd;  // set the triangle's bit
    logic nxt_rd;    // read lowest nonzero bitmap word
    logic nxt_upd;   // clear lowest bit, load result
    logic nxt_none;  // load empty result
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic edge_ok;     // input edge number within table
    logic adj_end;     // slot holds the end mark
    logic adj_mark;    // slot holds a usable triangle
    logic slot_last;   // current slot is the edge's last
    logic any_marked;  // bitmap holds at least one bit
  } sts_t;

  // index of the lowest set bit of a word (zero when none)
  function automatic logic [BIT_W-1:0] lsb_index(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

// ===== sv/etsg_ram.sv =====
// Generic simple dual port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module etsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/etsg_dp.sv =====
// Datapath: adjacency table RAM, word-organized membership bitmap RAM with
// per-word nonzero flags, marked count and result registers. Uses etsg_pkg, etsg_ram.
`default_nettype none
module etsg_dp
  import etsg_pkg::*;
#(
  parameter int MAX_TRIANGLES = 1024,
  parameter int MAX_EDGES     = 2048,
  parameter int ADJ_SLOTS     = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [EDGE_W-1:0] in_edge_number,
  input  wire logic              in_slot,
  input  wire logic [VAL_W-1:0]  in_slot_triangle,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  output logic      [IDX_W-1:0]  out_triangle_index,
  output logic                   out_found,
  output logic                   out_last,
  output logic      [REM_W-1:0]  out_remaining_count
);

  localparam int ADJ_DEPTH = MAX_EDGES * ADJ_SLOTS;
  localparam int ADJ_AW    = (ADJ_DEPTH > 1) ? $clog2(ADJ_DEPTH) : 1;
  localparam int NUM_WORDS = (MAX_TRIANGLES + WORD_W - 1) / WORD_W;
  localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int SL_W      = (ADJ_SLOTS > 1) ? $clog2(ADJ_SLOTS) : 1;
  localparam int CNT_W     = $clog2(MAX_TRIANGLES + 1);

  // held edge and slot of the add in progress
  logic [EDGE_W-1:0] edge_r;
  logic [SL_W-1:0]   slot_r;
  // bitmap word and bit being worked on
  logic [WIDX_W-1:0] widx_r;
  logic [BIT_W-1:0]  bit_r;
  // per-word nonzero flags; a clear flag means the word reads as zero
  logic [NUM_WORDS-1:0] nz_r, nz_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  logic              adj_we;
  logic [ADJ_AW-1:0] adj_waddr, adj_raddr;
  logic [VAL_W-1:0]  adj_rdata;

  logic              bm_we;
  logic [WIDX_W-1:0] bm_raddr;
  logic [WORD_W-1:0] bm_wdata, bm_rdata, bm_word;

  logic [WIDX_W-1:0] raw_widx, first_widx;
  logic [BIT_W-1:0]  low_bit;
  logic [WORD_W-1:0] word_cleared;
  logic [CNT_W-1:0]  cnt_dec;

  // range checks on the input beat
  assign sts.edge_ok = 32'(in_edge_number) < MAX_EDGES;

  // adjacency table
  assign adj_we    = cmd.adj_wr && sts.edge_ok && (32'(in_slot) < ADJ_SLOTS);
  assign adj_waddr = ADJ_AW'(32'(in_edge_number) * ADJ_SLOTS + 32'(in_slot));
  assign adj_raddr = ADJ_AW'(32'(edge_r) * ADJ_SLOTS + 32'(slot_r));

  etsg_ram #(.WIDTH(VAL_W), .DEPTH(ADJ_DEPTH)) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (in_slot_triangle),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  // classify the slot value just read
  assign sts.adj_end   = adj_rdata == END_MARK;
  assign sts.adj_mark  = !adj_rdata[VAL_W-1] && (32'(adj_rdata) < MAX_TRIANGLES);
  assign sts.slot_last = 32'(slot_r) == ADJ_SLOTS - 1;
  assign raw_widx      = WIDX_W'(adj_rdata[IDX_W-1:BIT_W]);

  // lowest nonzero bitmap word
  always_comb begin
    first_widx = '0;
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (nz_r[i]) first_widx = WIDX_W'(i);
    end
  end
  assign sts.any_marked = |nz_r;

  // bitmap read-modify-write
  assign bm_raddr     = cmd.nxt_rd ? first_widx : raw_widx;
  assign bm_word      = nz_r[widx_r] ? bm_rdata : '0;
  assign low_bit      = lsb_index(bm_word);
  assign word_cleared = bm_word & ~(WORD_W'(1) << low_bit);
  assign bm_we        = cmd.mark_upd || cmd.nxt_upd;
  assign bm_wdata     = cmd.nxt_upd ? word_cleared : (bm_word | (WORD_W'(1) << bit_r));

  etsg_ram #(.WIDTH(WORD_W), .DEPTH(NUM_WORDS)) u_bm_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (widx_r),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  assign cnt_dec = (cnt_r != '0) ? cnt_r - 1'b1 : cnt_r;

  // flags and count
  always_comb begin
    nz_nxt  = nz_r;
    cnt_nxt = cnt_r;
    if (cmd.mark_upd) begin
      nz_nxt[widx_r] = 1'b1;
      if (!bm_word[bit_r]) cnt_nxt = cnt_r + 1'b1;
    end else if (cmd.nxt_upd) begin
      nz_nxt[widx_r] = |word_cleared;
      cnt_nxt        = cnt_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nz_r  <= '0;
      cnt_r <= '0;
    end else begin
      nz_r  <= nz_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // working registers and result
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      edge_r <= in_edge_number;
      slot_r <= '0;
    end else if (cmd.slot_inc) begin
      slot_r <= slot_r + 1'b1;
    end
    if (cmd.mark_rd) begin
      widx_r <= raw_widx;
      bit_r  <= adj_rdata[BIT_W-1:0];
    end else if (cmd.nxt_rd) begin
      widx_r <= first_widx;
    end
    if (cmd.nxt_upd) begin
      out_triangle_index  <= IDX_W'({widx_r, low_bit});
      out_found           <= 1'b1;
      out_last            <= cnt_dec == '0;
      out_remaining_count <= REM_W'(cnt_dec);
    end else if (cmd.nxt_none) begin
      out_triangle_index  <= '0;
      out_found           <= 1'b0;
      out_last            <= 1'b0;
      out_remaining_count <= '0;
    end
  end

endmodule
`default_nettype wire

// ===== sv/etsg_ctrl.sv =====
// Controller: sequences writes, slot scans of an add and next lookups.
// Uses etsg_pkg; drives the datapath only through cmd_t and reads sts_t.
`default_nettype none
module etsg_ctrl
  import etsg_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [OP_W-1:0] in_operation,
  input  wire sts_t            sts,
  output cmd_t                 cmd,
  output logic                 busy,
  output logic                 out_valid
);

  typedef enum logic [2:0] {
    S_IDLE, S_ADJ_RD, S_ADJ_CHK, S_MARK, S_NXT_RD, S_NXT_UPD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // next state, commands and result strobe
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_operation)
            OP_WRITE: cmd.adj_wr = 1'b1;
            OP_ADD: begin
              if (sts.edge_ok) begin
                cmd.latch = 1'b1;
                state_nxt = S_ADJ_RD;
              end
            end
            OP_NEXT: state_nxt = S_NXT_RD;
            default: ;
          endcase
        end
      end
      S_ADJ_RD: state_nxt = S_ADJ_CHK;
      S_ADJ_CHK: begin
        if (sts.adj_end) begin
          state_nxt = S_IDLE;
        end else if (sts.adj_mark) begin
          cmd.mark_rd = 1'b1;
          state_nxt   = S_MARK;
        end else if (sts.slot_last) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.slot_inc = 1'b1;
          state_nxt    = S_ADJ_RD;
        end
      end
      S_MARK: begin
        cmd.mark_upd = 1'b1;
        if (sts.slot_last) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.slot_inc = 1'b1;
          state_nxt    = S_ADJ_RD;
        end
      end
      S_NXT_RD: begin
        if (sts.any_marked) begin
          cmd.nxt_rd = 1'b1;
          state_nxt  = S_NXT_UPD;
        end else begin
          cmd.nxt_none  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_NXT_UPD: begin
        cmd.nxt_upd   = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold state and the strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== sv/edge_triangle_set_gather.sv =====
// Edge triangle set gather, top level. Write: done while idle, busy stays low.
// Add: each slot takes an adjacency RAM read and check, plus a bitmap
// read-modify-write when the slot marks a triangle; ended early by the end mark.
// Next: bitmap word read, update, then registered out_valid (no update when empty).
// Synchronous reset clears the per-word bitmap flags and count at once, no sweep;
// the adjacency table is undefined until written. The receiver cannot stall.
`default_nettype none
module edge_triangle_set_gather
  import etsg_pkg::*;
#(
  parameter int MAX_TRIANGLES = 1024,
  parameter int MAX_EDGES     = 2048,
  parameter int ADJ_SLOTS     = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [OP_W-1:0]   in_operation,
  input  wire logic [EDGE_W-1:0] in_edge_number,
  input  wire logic              in_slot,
  input  wire logic [VAL_W-1:0]  in_slot_triangle,
  output logic                   out_valid,
  output logic      [IDX_W-1:0]  out_triangle_index,
  output logic                   out_found,
  output logic                   out_last,
  output logic      [REM_W-1:0]  out_remaining_count
);

  cmd_t cmd;
  sts_t sts;

  etsg_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy),
    .out_valid    (out_valid)
  );

  etsg_dp #(
    .MAX_TRIANGLES (MAX_TRIANGLES),
    .MAX_EDGES     (MAX_EDGES),
    .ADJ_SLOTS     (ADJ_SLOTS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_edge_number      (in_edge_number),
    .in_slot             (in_slot),
    .in_slot_triangle    (in_slot_triangle),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_triangle_index  (out_triangle_index),
    .out_found           (out_found),
    .out_last            (out_last),
    .out_remaining_count (out_remaining_count)
  );

  // a result beat lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // a result beat only ends a busy lookup
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a lookup in progress");

  // an empty result carries zero index and count; a last result has zero left
  a_result_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_found ? (out_last == (out_remaining_count == '0))
                             : (out_triangle_index == '0 && out_remaining_count == '0
                                && !out_last)))
    else $error("result flags disagree with count");

endmodule
`default_nettype wire

// ===== sim/edge_triangle_set_gather_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for edge_triangle_set_gather: adjacency writes, edge adds
// and next-triangle reads, checked against an in-bench predictor. Depends on etsg_pkg.
module edge_triangle_set_gather_tb;
  import etsg_pkg::*;

  localparam int TRI_N          = 1024;
  localparam int EDGE_N         = 2048;
  localparam int SLOT_N         = 2;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 20;
  // operation code the block ignores
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [EDGE_W-1:0] edge_no;
    logic              slot;
    logic [VAL_W-1:0]  val;
    int                gap;    // idle cycles before this beat is offered
    bit                drain;  // hold until every pending triangle has come back
  } beat_t;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic             found;
    logic             last;
    logic [REM_W-1:0] remaining;
  } triangle_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [OP_W-1:0]   in_operation = '0;
  logic [EDGE_W-1:0] in_edge_number = '0;
  logic              in_slot = 1'b0;
  logic [VAL_W-1:0]  in_slot_triangle = '0;
  logic              out_valid;
  logic [IDX_W-1:0]  out_triangle_index;
  logic              out_found;
  logic              out_last;
  logic [REM_W-1:0]  out_remaining_count;

  // gather state as the block should hold it
  logic [VAL_W-1:0] adj_mem [SLOT_N*EDGE_N];
  bit   [TRI_N-1:0] member_map = '0;
  int               marked_cnt = 0;
  triangle_t        triangle_q[$];

  // stimulus generation state
  beat_t            beat_q[$];
  bit               gen_written [SLOT_N*EDGE_N];
  logic [VAL_W-1:0] gen_val [SLOT_N*EDGE_N];
  int               ready_edges[$];
  int               useful_cnt = 0;
  bit               steady = 1'b0;
  bit               drain_pending = 1'b0;

  int next_issued = 0;
  int results_seen = 0;
  int errors = 0;
  int hold_cnt = 0;
  int idle_cycles = 0;

  edge_triangle_set_gather u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_edge_number     (in_edge_number),
    .in_slot            (in_slot),
    .in_slot_triangle   (in_slot_triangle),
    .out_valid          (out_valid),
    .out_triangle_index (out_triangle_index),
    .out_found          (out_found),
    .out_last           (out_last),
    .out_remaining_count(out_remaining_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // triangle values: plain, clustered for repeats, end mark, any raw pattern
  function automatic logic [VAL_W-1:0] pick_val();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return VAL_W'($urandom_range(0, TRI_N - 1));
    if (r < 75) return VAL_W'($urandom_range(0, 15));
    if (r < 88) return END_MARK;
    return VAL_W'($urandom_range(0, 2047));
  endfunction

  // an add may only touch slots that were written before
  function automatic bit readable(input int e);
    return gen_written[e*SLOT_N] &&
           (gen_val[e*SLOT_N] == END_MARK || gen_written[e*SLOT_N + 1]);
  endfunction

  task automatic queue_beat(input logic [OP_W-1:0] op, input int e, input int s,
                            input logic [VAL_W-1:0] v);
    beat_t b;
    b.op = op;
    b.edge_no = EDGE_W'(e);
    b.slot = s[0];
    b.val = v;
    b.gap = pick_gap();
    b.drain = drain_pending;
    drain_pending = 1'b0;
    if (op == OP_WRITE) begin
      gen_written[e*SLOT_N + s] = 1'b1;
      gen_val[e*SLOT_N + s] = v;
    end
    if (op != OP_NONE) useful_cnt++;
    beat_q.push_back(b);
  endtask

  task automatic queue_next();
    queue_beat(OP_NEXT, $urandom_range(0, EDGE_N - 1), $urandom_range(0, 1), pick_val());
  endtask

  // one burst of random traffic; most bursts load edges, add them, then drain
  task automatic gen_burst();
    int kind;
    int n;
    int k;
    int m;
    int e;
    logic [VAL_W-1:0] v;
    int fresh[$];
    kind = $urandom_range(0, 99);
    steady = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 19) == 0) drain_pending = 1'b1;
    if (kind < 70) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        e = $urandom_range(0, EDGE_N - 1);
        v = pick_val();
        queue_beat(OP_WRITE, e, 0, v);
        if (v != END_MARK || $urandom_range(0, 1) == 1)
          queue_beat(OP_WRITE, e, 1, pick_val());
        fresh.push_back(e);
        ready_edges.push_back(e);
      end
      k = $urandom_range(1, n + 3);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 2) != 0) e = fresh[$urandom_range(0, fresh.size() - 1)];
        else e = ready_edges[$urandom_range(0, ready_edges.size() - 1)];
        if (readable(e)) queue_beat(OP_ADD, e, $urandom_range(0, 1), pick_val());
      end
      // now and then let the set build up instead of draining it
      if ($urandom_range(0, 9) != 0) begin
        m = $urandom_range(0, 2*k + 2);
        for (int i = 0; i < m; i++) queue_next();
      end
    end else if (kind < 85) begin
      e = $urandom_range(0, EDGE_N - 1);
      case ($urandom_range(0, 3))
        0: queue_beat(OP_WRITE, e, $urandom_range(0, 1), pick_val());
        1: begin
          if (ready_edges.size() != 0) e = ready_edges[$urandom_range(0, ready_edges.size() - 1)];
          if (readable(e)) queue_beat(OP_ADD, e, $urandom_range(0, 1), pick_val());
          else queue_next();
        end
        2: queue_next();
        default: queue_beat(OP_NONE, e, $urandom_range(0, 1), VAL_W'($urandom_range(0, 2047)));
      endcase
    end else begin
      m = $urandom_range(1, 20);
      for (int i = 0; i < m; i++) queue_next();
    end
  endtask

  // advance the expected gather state by one accepted beat
  task automatic gather_apply(input beat_t b);
    triangle_t res;
    logic [VAL_W-1:0] v;
    bit done;
    int t;
    case (b.op)
      OP_WRITE: adj_mem[int'(b.edge_no)*SLOT_N + int'(b.slot)] = b.val;
      OP_ADD: begin
        done = 1'b0;
        for (int s = 0; s < SLOT_N; s++) begin
          if (!done) begin
            v = adj_mem[int'(b.edge_no)*SLOT_N + s];
            if (v == END_MARK) begin
              done = 1'b1;
            end else if (!v[VAL_W-1] && !member_map[v[IDX_W-1:0]]) begin
              member_map[v[IDX_W-1:0]] = 1'b1;
              marked_cnt++;
            end
          end
        end
      end
      OP_NEXT: begin
        next_issued++;
        t = -1;
        for (int i = 0; i < TRI_N; i++)
          if (t < 0 && member_map[i]) t = i;
        res.idx = '0;
        res.found = 1'b0;
        res.last = 1'b0;
        res.remaining = '0;
        if (t >= 0) begin
          member_map[t] = 1'b0;
          marked_cnt--;
          res.idx = IDX_W'(t);
          res.found = 1'b1;
          res.last = (marked_cnt == 0);
          res.remaining = REM_W'(marked_cnt);
        end
        triangle_q.push_back(res);
      end
      default: ;
    endcase
  endtask

  // four-state compare so an unknown result bit counts as a mismatch
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // driver: offer the head beat after its gap, pop it once accepted
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        gather_apply(beat_q.pop_front());
        hold_cnt = 0;
      end else if (!start) begin
        hold_cnt++;
      end
      if (!(start && busy)) begin
        if (beat_q.size() != 0 && hold_cnt >= beat_q[0].gap &&
            (!beat_q[0].drain || next_issued == results_seen)) begin
          in_operation <= beat_q[0].op;
          in_edge_number <= beat_q[0].edge_no;
          in_slot <= beat_q[0].slot;
          in_slot_triangle <= beat_q[0].val;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest expected triangle
  always @(posedge clk) begin
    triangle_t want;
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (triangle_q.size() == 0) begin
        $error("result beat with nothing expected: index %0d", out_triangle_index);
        errors++;
      end else begin
        want = triangle_q.pop_front();
        check_field("triangle_index", 32'(want.idx), 32'(out_triangle_index));
        check_field("found", 32'(want.found), 32'(out_found));
        check_field("last", 32'(want.last), 32'(out_last));
        check_field("remaining_count", 32'(want.remaining), 32'(out_remaining_count));
      end
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid === 1'b1) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    // directed: empty set, extreme values, end mark, bad negatives, repeats
    queue_next();
    queue_beat(OP_WRITE, 0, 0, VAL_W'(0));
    queue_beat(OP_WRITE, 0, 1, VAL_W'(TRI_N - 1));
    queue_beat(OP_WRITE, EDGE_N - 1, 0, END_MARK);
    queue_beat(OP_WRITE, EDGE_N - 1, 1, VAL_W'(5));
    queue_beat(OP_WRITE, 1, 0, 11'h400);  // most negative value
    queue_beat(OP_WRITE, 1, 1, VAL_W'(7));
    queue_beat(OP_WRITE, 2, 0, 11'h7FE);  // negative, not the end mark
    queue_beat(OP_WRITE, 2, 1, END_MARK);
    queue_beat(OP_NONE, EDGE_N - 1, 1, 11'h7FF);
    queue_beat(OP_ADD, 0, 0, '0);
    queue_beat(OP_ADD, 0, 1, 11'h7FF);    // same triangles again
    queue_beat(OP_ADD, EDGE_N - 1, 0, '0);
    queue_beat(OP_ADD, 1, 0, '0);
    queue_beat(OP_ADD, 2, 0, '0);
    for (int i = 0; i < 4; i++) queue_next();
    ready_edges = '{0, 1, 2, EDGE_N - 1};

    // random part; the first burst waits for the directed results to drain
    drain_pending = 1'b1;
    useful_cnt = 0;
    while (useful_cnt < RANDOM_ITEMS) gen_burst();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (beat_q.size() != 0 || start || next_issued != results_seen) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== edge_triangle_set_gather.f =====
sv/etsg_pkg.sv
sv/etsg_ram.sv
sv/etsg_dp.sv
sv/etsg_ctrl.sv
sv/edge_triangle_set_gather.sv
sim/edge_triangle_set_gather_tb.sv
